@@ rtl/smct_pkg.sv @@
// Shared types and codes for the sorted multiset count table.
package smct_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 16;
	localparam int TOTAL_W = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_ABSENT = 2'd2,
		STAT_RSVD   = 2'd3
	} status_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		status_t            status;
		logic               is_empty;
		logic [VALUE_W-1:0] smallest_value;
		logic [TOTAL_W-1:0] total_count;
		logic [COUNT_W-1:0] value_count;
		logic               present;
	} result_t;

endpackage

@@ rtl/sorted_multiset_count_table_top.sv @@
// Top level of the sorted multiset count table.
//
//  channel  dir  tdata                                   tuser
//  s_*      in   value[31:0] occurrences[47:32]          command[1:0]
//  m_*      out  present, value_count, total_count,      -
//                smallest_value, is_empty, status
//
// A command runs a linear search that reads k entries through the single read port, then m
// shift steps (one per moved entry, plus one for the insert write); k + m stays within
// TABLE_DEPTH + 1.
// The next command is accepted in the cycle after the result load.
// Reset empties the table at once; no clearing pass is needed.
// The result waits in an output register; a new command is taken while it waits, and only
// the final result load stalls on m_tready.
module sorted_multiset_count_table_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // value[31:0], occurrences[47:32]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// present[0], value_count[16:1], total_count[40:17], smallest_value[72:41],
	// is_empty[73], status[75:74], zero fill[79:76]
	output logic [79:0] m_tdata
);
	import smct_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	entry_t          mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	entry_t          mem_rdata;
	result_t         res;

	smct_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	smct_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser)),
		.in_value  (s_tdata[31:0]),
		.in_occ    (s_tdata[47:32]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	assign m_tdata = {4'd0, res};

endmodule

@@ rtl/smct_mem.sv @@
// Entry store: one write port, one registered read port.
module smct_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  smct_pkg::entry_t     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output smct_pkg::entry_t     rdata
);
	import smct_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/smct_ctrl.sv @@
// Command sequencer: search, shift, update and result register.
module smct_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int CW    = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  smct_pkg::cmd_t       in_cmd,
	input  logic [31:0]          in_value,
	input  logic [15:0]          in_occ,
	output logic                 out_valid,
	input  logic                 out_ready,
	output smct_pkg::result_t    out_res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output smct_pkg::entry_t     mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  smct_pkg::entry_t     mem_rdata
);
	import smct_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DECIDE, ST_SHUP, ST_SHDN, ST_INS, ST_FIN, ST_RES
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [31:0]        val_q;
	logic [15:0]        occ_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      pos_q;
	logic               found_q;
	logic [15:0]        cnt_q;
	logic [CW-1:0]      used_q;
	logic [23:0]        total_q;
	logic               pres_q;
	logic [15:0]        rcnt_q;
	status_t            stat_q;
	logic               out_valid_q;
	result_t            res_q;

	logic               hit, less, last_idx, full, at_end, pos_hit;
	logic [AW-1:0]      pos_a;
	logic [16:0]        sum_c;
	logic [15:0]        new_c;
	logic [15:0]        add_amt;
	logic [24:0]        tot_sum;
	logic [23:0]        tot_new;
	logic               out_free;

	assign hit      = mem_rdata.value == val_q;
	assign less     = $signed(val_q) < $signed(mem_rdata.value);
	assign last_idx = CW'(idx_q) == (used_q - CW'(1));
	assign full     = used_q == CW'(DEPTH);
	assign at_end   = pos_q == used_q;
	assign pos_hit  = pos_q == (used_q - CW'(1));
	assign pos_a    = pos_q[AW-1:0];
	assign sum_c    = {1'b0, cnt_q} + {1'b0, occ_q};
	assign new_c    = sum_c[16] ? COUNT_MAX : sum_c[15:0];
	assign add_amt  = found_q ? (new_c - cnt_q) : occ_q;
	assign tot_sum  = {1'b0, total_q} + {9'd0, add_amt};
	assign tot_new  = tot_sum[24] ? TOTAL_MAX : tot_sum[23:0];
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = in_valid && (used_q != '0);
			end
			ST_SCAN: begin
				if (!hit && !less && !last_idx) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(idx_q + 1'b1);
				end
			end
			ST_DECIDE: begin
				if (cmd_q == CMD_ADD && occ_q != '0) begin
					if (found_q) begin
						mem_we    = 1'b1;
						mem_waddr = pos_a;
						mem_wdata = '{value: val_q, count: new_c};
					end else if (!full) begin
						if (at_end) begin
							mem_we    = 1'b1;
							mem_waddr = pos_a;
							mem_wdata = '{value: val_q, count: occ_q};
						end else begin
							mem_re    = 1'b1;
							mem_raddr = AW'(used_q - CW'(1));
						end
					end
				end else if (cmd_q == CMD_REMOVE && found_q) begin
					if (cnt_q > 16'd1) begin
						mem_we    = 1'b1;
						mem_waddr = pos_a;
						mem_wdata = '{value: val_q, count: cnt_q - 16'd1};
					end else if (!pos_hit) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(pos_a + 1'b1);
					end
				end
			end
			ST_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(idx_q + 1'b1);
				mem_wdata = mem_rdata;
				if (idx_q != pos_a) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(idx_q - 1'b1);
				end
			end
			ST_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(idx_q - 1'b1);
				mem_wdata = mem_rdata;
				if (!last_idx) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(idx_q + 1'b1);
				end
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = pos_a;
				mem_wdata = '{value: val_q, count: occ_q};
			end
			ST_FIN: begin
				mem_re = 1'b1;
			end
			ST_RES: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			stat_q      <= STAT_OK;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_cmd;
						val_q   <= in_value;
						occ_q   <= in_occ;
						found_q <= 1'b0;
						pos_q   <= '0;
						idx_q   <= '0;
						state_q <= (used_q == '0) ? ST_DECIDE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						pos_q   <= CW'(idx_q);
						cnt_q   <= mem_rdata.count;
						state_q <= ST_DECIDE;
					end else if (less) begin
						pos_q   <= CW'(idx_q);
						state_q <= ST_DECIDE;
					end else if (last_idx) begin
						pos_q   <= used_q;
						state_q <= ST_DECIDE;
					end else begin
						idx_q <= AW'(idx_q + 1'b1);
					end
				end
				ST_DECIDE: begin
					stat_q  <= STAT_OK;
					pres_q  <= found_q;
					rcnt_q  <= found_q ? cnt_q : 16'd0;
					state_q <= ST_FIN;
					if (cmd_q == CMD_ADD && occ_q != '0) begin
						if (found_q) begin
							total_q <= tot_new;
							rcnt_q  <= new_c;
						end else if (full) begin
							stat_q <= STAT_FULL;
						end else begin
							total_q <= tot_new;
							pres_q  <= 1'b1;
							rcnt_q  <= occ_q;
							if (at_end) begin
								used_q <= used_q + CW'(1);
							end else begin
								idx_q   <= AW'(used_q - CW'(1));
								state_q <= ST_SHUP;
							end
						end
					end else if (cmd_q == CMD_REMOVE) begin
						if (!found_q) begin
							stat_q <= STAT_ABSENT;
						end else begin
							if (total_q != '0) begin
								total_q <= total_q - 24'd1;
							end
							if (cnt_q > 16'd1) begin
								rcnt_q <= cnt_q - 16'd1;
							end else begin
								pres_q <= 1'b0;
								rcnt_q <= 16'd0;
								if (pos_hit) begin
									used_q <= used_q - CW'(1);
								end else begin
									idx_q   <= AW'(pos_a + 1'b1);
									state_q <= ST_SHDN;
								end
							end
						end
					end
				end
				ST_SHUP: begin
					if (idx_q == pos_a) begin
						state_q <= ST_INS;
					end else begin
						idx_q <= AW'(idx_q - 1'b1);
					end
				end
				ST_SHDN: begin
					if (last_idx) begin
						used_q  <= used_q - CW'(1);
						state_q <= ST_FIN;
					end else begin
						idx_q <= AW'(idx_q + 1'b1);
					end
				end
				ST_INS: begin
					used_q  <= used_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free) begin
						res_q.present        <= pres_q;
						res_q.value_count    <= rcnt_q;
						res_q.total_count    <= total_q;
						res_q.smallest_value <= (used_q != '0) ? mem_rdata.value : 32'd0;
						res_q.is_empty       <= used_q == '0;
						res_q.status         <= stat_q;
						out_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// fill count never passes the table depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// every stored entry holds at least one occurrence; the fill count lags the
	// total while a delete shifts the tail down
	a_total_ge_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SHDN) |-> (total_q >= 24'(used_q)))
		else $error("total below entry count");

	// a shift step never reads the entry it is writing
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write collide");

	// an empty table reports a zero total and zero minimum
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.is_empty) |->
		(res_q.total_count == '0 && res_q.smallest_value == '0))
		else $error("empty result carries data");
`endif

endmodule

@@ bench/sorted_multiset_count_table_top_tb.sv @@
// Self-checking stream testbench for the sorted multiset count table.
`timescale 1ns / 100ps

module sorted_multiset_count_table_top_tb;
	import smct_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int RUN_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
	localparam int LONG_HOLD = 400;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] value;
		logic [15:0] occ;
		int          gap;
		bit          drain_first;
	} table_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_QUERY;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;

	table_cmd_t  pending_cmds[$];
	result_t     expected_results[$];

	// shadow copy of the table
	logic signed [31:0] tbl_value[TABLE_DEPTH];
	logic [15:0]        tbl_count[TABLE_DEPTH];
	int                 tbl_used = 0;
	logic [23:0]        tbl_total = '0;

	int          fail_count = 0;
	int          results_seen = 0;
	int          cycle_count = 0;
	int          gap_count = 0;
	int          hold_left = 0;
	bit          long_hold_done = 0;
	int unsigned rx_roll;
	table_cmd_t  next_cmd;

	sorted_multiset_count_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// Lowest index whose value is >= v: the entry itself, or where v would go.
	function automatic void find_slot(input logic signed [31:0] v, output int slot,
			output bit hit);
		slot = tbl_used;
		hit = 0;
		for (int i = tbl_used - 1; i >= 0; i--) begin
			if (v <= tbl_value[i]) begin
				slot = i;
				hit = (v == tbl_value[i]);
			end
		end
	endfunction

	function automatic void raise_total(input logic [16:0] delta);
		logic [24:0] sum;
		sum = tbl_total + delta;
		tbl_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[23:0];
	endfunction

	task automatic apply_table_command(input cmd_t cmd, input logic signed [31:0] v,
			input logic [15:0] occ);
		int          slot;
		bit          hit;
		logic [16:0] grown;
		status_t     st;
		result_t     r;
		st = STAT_OK;
		find_slot(v, slot, hit);
		case (cmd)
			CMD_ADD: begin
				if (occ != 0) begin
					if (hit) begin
						grown = tbl_count[slot] + occ;
						if (grown > COUNT_MAX)
							grown = COUNT_MAX;
						raise_total(grown - tbl_count[slot]);
						tbl_count[slot] = grown[15:0];
					end else if (tbl_used >= TABLE_DEPTH) begin
						st = STAT_FULL;
					end else begin
						for (int i = tbl_used; i > slot; i--) begin
							tbl_value[i] = tbl_value[i-1];
							tbl_count[i] = tbl_count[i-1];
						end
						tbl_value[slot] = v;
						tbl_count[slot] = occ;
						tbl_used++;
						raise_total(occ);
					end
				end
			end
			CMD_REMOVE: begin
				if (!hit) begin
					st = STAT_ABSENT;
				end else begin
					if (tbl_total != 0)
						tbl_total--;
					if (tbl_count[slot] <= 1) begin
						for (int i = slot; i + 1 < tbl_used; i++) begin
							tbl_value[i] = tbl_value[i+1];
							tbl_count[i] = tbl_count[i+1];
						end
						tbl_used--;
					end else begin
						tbl_count[slot]--;
					end
				end
			end
			default: ;
		endcase
		find_slot(v, slot, hit);
		r.present = hit;
		r.value_count = hit ? tbl_count[slot] : '0;
		r.total_count = tbl_total;
		r.smallest_value = (tbl_used > 0) ? tbl_value[0] : '0;
		r.is_empty = (tbl_used == 0);
		r.status = st;
		expected_results.push_back(r);
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	task automatic queue_cmd(input cmd_t cmd, input logic [31:0] value,
			input logic [15:0] occ, input int gap, input bit drain_first);
		table_cmd_t c;
		c.cmd = cmd;
		c.value = value;
		c.occ = occ;
		c.gap = gap;
		c.drain_first = drain_first;
		pending_cmds.push_back(c);
	endtask

	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	function automatic logic [15:0] pick_occ();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 16'd1;
		if (roll < 70)
			return 16'($urandom_range(2, 5));
		if (roll < 80)
			return 16'd0;
		if (roll < 92)
			return 16'($urandom);
		return 16'($urandom_range(65000, 65535));
	endfunction

	// Sender: predicts each accepted transaction, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_QUERY;
			gap_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_table_command(cmd_t'(s_tuser), s_tdata[31:0], s_tdata[47:32]);
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (gap_count < pending_cmds[0].gap) begin
					gap_count <= gap_count + 1;
					s_tvalid <= 1'b0;
				end else if (pending_cmds[0].drain_first && expected_results.size() != 0) begin
					s_tvalid <= 1'b0;
				end else begin
					next_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_cmd.occ, next_cmd.value};
					s_tuser <= next_cmd.cmd;
					gap_count <= 0;
				end
			end
		end
	end

	// Receiver backpressure, with one long hold-off to fill the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 250) begin
			long_hold_done <= 1;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (cycle_count[8:7] == 2'b11) begin
			m_tready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 60) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				if (rx_roll < 85)
					hold_left <= $urandom_range(0, 2);
				else if (rx_roll < 97)
					hold_left <= $urandom_range(3, 11);
				else
					hold_left <= $urandom_range(19, 49);
			end
		end
	end

	// Monitor: each result transaction against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				fail_count++;
			end else begin
				automatic result_t want = expected_results.pop_front();
				automatic result_t got = result_t'(m_tdata[75:0]);
				compare_field("present", 32'(want.present), 32'(got.present));
				compare_field("value_count", 32'(want.value_count), 32'(got.value_count));
				compare_field("total_count", 32'(want.total_count), 32'(got.total_count));
				compare_field("smallest_value", want.smallest_value, got.smallest_value);
				compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
				compare_field("status", 32'(want.status), 32'(got.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [31:0] pool[20];
		int unsigned roll;
		int          add_pct;
		int          rem_pct;
		logic [31:0] val;
		cmd_t        cmd;

		// empty table, zero-copy add, extremes, count saturation, removes
		queue_cmd(CMD_QUERY, 32'd0, 16'd0, 0, 0);
		queue_cmd(CMD_REMOVE, 32'd0, 16'd0, 0, 0);
		queue_cmd(CMD_ADD, 32'd7, 16'd0, 0, 0);
		queue_cmd(CMD_ADD, 32'h8000_0000, 16'd1, 0, 0);
		queue_cmd(CMD_ADD, 32'h7FFF_FFFF, 16'hFFFF, 0, 0);
		queue_cmd(CMD_ADD, 32'h7FFF_FFFF, 16'd9, 0, 0);
		queue_cmd(CMD_REMOVE, 32'h8000_0000, 16'hFFFF, 0, 0);
		queue_cmd(CMD_REMOVE, 32'h7FFF_FFFF, 16'd0, 0, 0);
		queue_cmd(CMD_RSVD, 32'h7FFF_FFFF, 16'hFFFF, 0, 0);
		// fill to capacity, each new value landing at the front
		for (int i = 0; i < TABLE_DEPTH - 1; i++)
			queue_cmd(CMD_ADD, 32'(1000000 - i * 77777), 16'(i + 1), 0, 0);
		queue_cmd(CMD_ADD, 32'd123, 16'd4, 0, 0);
		queue_cmd(CMD_REMOVE, 32'd123, 16'd0, 0, 0);

		for (int phase = 0; phase < 7; phase++) begin
			for (int k = 0; k < 20; k++) begin
				case (k)
					0: pool[k] = 32'h8000_0000;
					1: pool[k] = 32'h7FFF_FFFF;
					2: pool[k] = 32'h0000_0000;
					3: pool[k] = 32'hFFFF_FFFF;
					default: pool[k] = $urandom_range(0, 1) ? $urandom
						: 32'($signed($urandom_range(0, 40)) - 20);
				endcase
			end
			// alternate between growing and draining the table
			add_pct = (phase % 2 == 0) ? 65 : 20;
			rem_pct = (phase % 2 == 0) ? 20 : 65;
			for (int n = 0; n < 100; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < add_pct)
					cmd = CMD_ADD;
				else if (roll < add_pct + rem_pct)
					cmd = CMD_REMOVE;
				else if (roll < 95)
					cmd = CMD_QUERY;
				else
					cmd = CMD_RSVD;
				val = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 19)];
				queue_cmd(cmd, val, pick_occ(), (phase % 3 == 1) ? 0 : pick_gap(),
					n == 0 && phase != 0 && phase % 2 == 0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_cmds.size() != 0 || s_tvalid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
